// ----- design/iso2022jp_stream_decoder_unit_defines.svh -----
// Assertion macros used by the decoder checker.
`ifndef ISO2022JP_STREAM_DECODER_UNIT_DEFINES_SVH
`define ISO2022JP_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ISO2J_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ISO2J_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder check failed");

`endif

// ----- design/iso2j_pkg.sv -----
package iso2j_pkg;

    typedef enum logic [1:0] {
        SET_ASCII = 2'd0,
        SET_ROMAN = 2'd1,
        SET_KANA  = 2'd2,
        SET_KANJI = 2'd3
    } char_set_t;

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_SEEN  = 2'd1,
        ESC_INTRO = 2'd2
    } esc_phase_t;

    localparam logic [1:0] KIND_CODE    = 2'd0;
    localparam logic [1:0] KIND_PAIR    = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    localparam logic [7:0] BYTE_ESC     = 8'h1B;
    localparam logic [7:0] BYTE_SO      = 8'h0E;
    localparam logic [7:0] BYTE_SI      = 8'h0F;
    localparam logic [7:0] BYTE_YEN     = 8'h5C;
    localparam logic [7:0] BYTE_TILDE   = 8'h7E;
    localparam logic [7:0] INTRO_SINGLE = 8'h28;
    localparam logic [7:0] INTRO_MULTI  = 8'h24;
    localparam logic [7:0] FINAL_ROMAN  = 8'h4A;
    localparam logic [7:0] FINAL_KANA   = 8'h49;
    localparam logic [7:0] FINAL_K1978  = 8'h40;
    localparam logic [7:0] FINAL_K1983  = 8'h42;
    localparam logic [7:0] HIGH_BIT     = 8'h80;

    localparam logic [15:0] CP_YEN      = 16'h00A5;
    localparam logic [15:0] CP_OVERLINE = 16'h203E;
    // Halfwidth kana: 7-bit form 0x21..0x5F and 8-bit form 0xA1..0xDF.
    localparam logic [15:0] KANA7_BASE  = 16'hFF40;
    localparam logic [15:0] KANA8_BASE  = 16'hFEC0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
    } result_item_t;

endpackage

// ----- design/iso2022jp_stream_decoder_unit.sv -----
// ISO-2022-JP byte stream decoder.
// An accepted byte waits in stage one; its result is then registered in stage two.
// Throughput: one byte per cycle, limited only by the single result register.
// Reset (rst_n low, asynchronous) empties both stages and returns the decoder
// to the ASCII set with no escape, shift or kanji lead pending.
module iso2022jp_stream_decoder_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  iso2j_pkg::byte_item_t  byte_data,
    output logic                   result_valid,
    input  logic                   result_ready,
    output iso2j_pkg::result_item_t result_data
);

    // Stage one: the accepted byte waits here while the decode logic looks at it.
    logic                    in_valid_reg;
    iso2j_pkg::byte_item_t   in_item_reg;

    // Decoder state, updated when the byte in stage one moves on.
    iso2j_pkg::char_set_t    set_reg, set_next;
    iso2j_pkg::esc_phase_t   phase_reg, phase_next;
    logic                    shift_reg, shift_next;
    logic                    lead_pend_reg, lead_pend_next;
    logic [7:0]              lead_byte_reg, lead_byte_next;
    logic [7:0]              intro_reg, intro_next;

    // Stage two: the result register that faces the consumer.
    logic                    out_valid_reg;
    iso2j_pkg::result_item_t out_item_reg;

    // Decode outputs.
    logic                    emit;
    iso2j_pkg::result_item_t res;
    iso2j_pkg::char_set_t    cur_set;
    iso2j_pkg::esc_phase_t   cur_phase;
    logic                    cur_shift;
    logic                    cur_lead_pend;
    logic [7:0]              b;
    logic                    kana7;
    logic                    kana8;
    logic                    advance;

    // A byte with no result may always leave stage one; one with a result needs
    // the result register to be empty or emptying in this cycle.
    assign advance    = in_valid_reg && (!emit || !out_valid_reg || result_ready);
    assign byte_ready = !in_valid_reg || advance;

    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;

    always_comb
    begin
        b     = in_item_reg.in_byte;
        kana7 = (b > 8'h20) && (b <= 8'h5F);
        kana8 = (b > 8'hA0) && (b <= 8'hDF);

        // A first byte sees the reset state; the held lead and intro bytes are
        // never looked at then because nothing is pending.
        if (in_item_reg.first)
        begin
            cur_set       = iso2j_pkg::SET_ASCII;
            cur_phase     = iso2j_pkg::ESC_IDLE;
            cur_shift     = 1'b0;
            cur_lead_pend = 1'b0;
        end
        else
        begin
            cur_set       = set_reg;
            cur_phase     = phase_reg;
            cur_shift     = shift_reg;
            cur_lead_pend = lead_pend_reg;
        end

        set_next       = cur_set;
        phase_next     = cur_phase;
        shift_next     = cur_shift;
        lead_pend_next = cur_lead_pend;
        lead_byte_next = lead_byte_reg;
        intro_next     = intro_reg;
        emit           = 1'b0;
        res.kind       = iso2j_pkg::KIND_CODE;
        res.value      = 16'h0000;

        if (cur_lead_pend)
        begin
            // The trail byte is taken whatever it is, an ESC included.
            lead_pend_next = 1'b0;
            emit           = 1'b1;
            res.kind       = iso2j_pkg::KIND_PAIR;
            res.value      = {lead_byte_reg | iso2j_pkg::HIGH_BIT, b | iso2j_pkg::HIGH_BIT};
        end
        else
        begin
            case (cur_phase)
                iso2j_pkg::ESC_SEEN:
                begin
                    intro_next = b;
                    phase_next = iso2j_pkg::ESC_INTRO;
                end
                iso2j_pkg::ESC_INTRO:
                begin
                    phase_next = iso2j_pkg::ESC_IDLE;
                    if (intro_reg == iso2j_pkg::INTRO_SINGLE)
                    begin
                        if (b == iso2j_pkg::FINAL_ROMAN)
                            set_next = iso2j_pkg::SET_ROMAN;
                        else if (b == iso2j_pkg::FINAL_KANA)
                            set_next = iso2j_pkg::SET_KANA;
                        else
                            set_next = iso2j_pkg::SET_ASCII;
                    end
                    else if (intro_reg == iso2j_pkg::INTRO_MULTI)
                    begin
                        if (b == iso2j_pkg::FINAL_K1978 || b == iso2j_pkg::FINAL_K1983)
                            set_next = iso2j_pkg::SET_KANJI;
                        else
                            set_next = iso2j_pkg::SET_ASCII;
                    end
                end
                default:
                begin
                    if (b == iso2j_pkg::BYTE_ESC)
                    begin
                        phase_next = iso2j_pkg::ESC_SEEN;
                    end
                    else
                    begin
                        case (cur_set)
                            iso2j_pkg::SET_KANJI:
                            begin
                                lead_byte_next = b;
                                lead_pend_next = 1'b1;
                            end
                            iso2j_pkg::SET_KANA:
                            begin
                                emit = 1'b1;
                                if (kana7)
                                    res.value = iso2j_pkg::KANA7_BASE + {8'h00, b};
                                else
                                    res.kind = iso2j_pkg::KIND_INVALID;
                            end
                            iso2j_pkg::SET_ROMAN:
                            begin
                                if (b == iso2j_pkg::BYTE_SO)
                                begin
                                    shift_next = 1'b1;
                                end
                                else if (b == iso2j_pkg::BYTE_SI)
                                begin
                                    shift_next = 1'b0;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                    if (b == iso2j_pkg::BYTE_YEN)
                                        res.value = iso2j_pkg::CP_YEN;
                                    else if (b == iso2j_pkg::BYTE_TILDE)
                                        res.value = iso2j_pkg::CP_OVERLINE;
                                    else if (cur_shift && kana7)
                                        res.value = iso2j_pkg::KANA7_BASE + {8'h00, b};
                                    else if (kana8)
                                        res.value = iso2j_pkg::KANA8_BASE + {8'h00, b};
                                    else if (!b[7])
                                        res.value = {8'h00, b};
                                    else
                                        res.kind = iso2j_pkg::KIND_INVALID;
                                end
                            end
                            default:
                            begin
                                emit = 1'b1;
                                if (!b[7])
                                    res.value = {8'h00, b};
                                else
                                    res.kind = iso2j_pkg::KIND_INVALID;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            set_reg       <= iso2j_pkg::SET_ASCII;
            phase_reg     <= iso2j_pkg::ESC_IDLE;
            shift_reg     <= 1'b0;
            lead_pend_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
                in_valid_reg <= byte_valid;
            // A new result refills the register; otherwise a taken result empties it.
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                set_reg       <= set_next;
                phase_reg     <= phase_next;
                shift_reg     <= shift_next;
                lead_pend_reg <= lead_pend_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            in_item_reg <= byte_data;
        if (advance)
        begin
            lead_byte_reg <= lead_byte_next;
            intro_reg     <= intro_next;
            if (emit)
                out_item_reg <= res;
        end
    end

endmodule

// ----- design/iso2j_checker.sv -----
`include "iso2022jp_stream_decoder_unit_defines.svh"

module iso2j_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    result_valid,
    input logic                    result_ready,
    input iso2j_pkg::result_item_t result_data
);

    logic show_invalid;
    logic show_pair;

    assign show_invalid = result_valid && (result_data.kind == iso2j_pkg::KIND_INVALID);
    assign show_pair    = result_valid && (result_data.kind == iso2j_pkg::KIND_PAIR);

    `ISO2J_ASSERT_NEXT(a_hold_valid, result_valid && !result_ready, result_valid)
    `ISO2J_ASSERT_NEXT(a_hold_data, result_valid && !result_ready, $stable(result_data))
    `ISO2J_ASSERT_NOW(a_kind_known, result_valid, result_data.kind != 2'd3)
    `ISO2J_ASSERT_NOW(a_invalid_zero, show_invalid, result_data.value == 16'h0000)
    `ISO2J_ASSERT_NOW(a_pair_high, show_pair, result_data.value[15] && result_data.value[7])

endmodule

bind iso2022jp_stream_decoder_unit iso2j_checker u_iso2j_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);
